// ----- src/hpid_pkg.sv -----
`timescale 1ns / 1ps
package hpid_pkg;

  localparam int CFG_W     = 15;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POS_TOL,
    CFG_ANG_TOL,
    CFG_ANG_LIM,
    CFG_LIN_SPEED,
    CFG_GAIN_P,
    CFG_GAIN_I,
    CFG_GAIN_D,
    CFG_WIDE_TOL
  } cfg_idx_t;

  localparam logic [CFG_W-1:0] RST_POS_TOL    = 15'd26;
  localparam logic [CFG_W-1:0] RST_ANG_TOL    = 15'd205;
  localparam logic [CFG_W-1:0] RST_ANG_LIM    = 15'd2048;
  localparam logic [CFG_W-1:0] RST_LIN_SPEED  = 15'd819;
  localparam logic [CFG_W-1:0] RST_GAIN_P     = 15'd2048;
  localparam logic [CFG_W-1:0] RST_GAIN_I     = 15'd41;
  localparam logic [CFG_W-1:0] RST_GAIN_D     = 15'd410;
  localparam logic [CFG_W-1:0] RST_WIDE_TOL   = 15'd614;

  localparam int CI_W   = 34;
  localparam int CW     = 38;
  localparam int ZW     = 21;
  localparam int ANG_W  = 17;
  localparam int ERR_W  = 18;
  localparam int SUM_W  = 40;
  localparam int MA_W   = 24;
  localparam int MB_W   = 18;
  localparam int PROD_W = 42;
  localparam int DIST_W = 34;
  localparam int QACC_W = 33;
  localparam int INT_W  = 14;
  localparam int DER_W  = 23;

  localparam int ATAN_SIZE  = 24;
  localparam int ATAN_IDX_W = 5;

  localparam logic signed [ZW-1:0]    PI_Q16         = 21'sd205887;
  localparam logic signed [ERR_W-1:0] PI_Q12         = 18'sd12868;
  localparam logic signed [ERR_W-1:0] TWO_PI_Q12     = 18'sd25736;
  localparam logic signed [16:0]      INTEGRAL_LIMIT = 17'sd4096;
  localparam logic [CW-1:0]           NORM_LIMIT     = 38'd536870912;
  localparam logic [CW-1:0]           NORM_LIMIT4    = 38'd33554432;
  localparam logic signed [MB_W-1:0]  RECIP_10       = 18'sd52429;
  localparam int                      RECIP_SHIFT    = 19;

  localparam logic [ZW-1:0] ATAN_Q16 [ATAN_SIZE] = '{
    21'd51472, 21'd30386, 21'd16055, 21'd8150, 21'd4091, 21'd2047, 21'd1024, 21'd512,
    21'd256, 21'd128, 21'd64, 21'd32, 21'd16, 21'd8, 21'd4, 21'd2,
    21'd1, 21'd0, 21'd0, 21'd0, 21'd0, 21'd0, 21'd0, 21'd0
  };

  typedef enum logic [1:0] {C_IDLE, C_NORM, C_ITER, C_DONE} cordic_state_t;

  typedef enum logic [4:0] {
    CS_IDLE, CS_DX, CS_DY, CS_TOL, CS_WW, CS_XX, CS_YY, CS_ZZ, CS_XY, CS_WZ, CS_XZ,
    CS_WY, CS_YAW_GO, CS_YAW_WAIT, CS_BRG_GO, CS_BRG_WAIT, CS_ERR, CS_DIV, CS_MP,
    CS_MI, CS_MD, CS_DONE
  } ctrl_state_t;

  typedef enum logic [3:0] {
    MUL_NONE, MUL_DX, MUL_DY, MUL_TOL, MUL_WW, MUL_XX, MUL_YY, MUL_ZZ, MUL_XY,
    MUL_WZ, MUL_XZ, MUL_WY, MUL_RECIP, MUL_P, MUL_I, MUL_D
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    mul_sel_t mul;
    logic     cordic_start;
    logic     cordic_brg;
    logic     err_latch;
    logic     finish;
  } dp_cmd_t;

  typedef struct packed {
    logic op;
    logic near;
    logic cordic_done;
  } dp_status_t;

  typedef struct packed {
    logic               op;
    logic [3:0]         robot_index;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic signed [15:0] goal_x;
    logic signed [15:0] goal_y;
    logic signed [14:0] goal_angle;
  } tick_t;

  typedef struct packed {
    logic [14:0]        linear_velocity;
    logic signed [15:0] angular_velocity;
    logic               reached;
  } res_t;

endpackage

// ----- src/hpid_if.sv -----
`timescale 1ns / 1ps
interface hpid_tick_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic [3:0]         robot_index;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic signed [15:0] quat_w;
  logic signed [15:0] goal_x;
  logic signed [15:0] goal_y;
  logic signed [14:0] goal_angle;
  modport source (output valid, op, robot_index, pos_x, pos_y, quat_x, quat_y, quat_z,
                  quat_w, goal_x, goal_y, goal_angle, input ready);
  modport sink (input valid, op, robot_index, pos_x, pos_y, quat_x, quat_y, quat_z,
                quat_w, goal_x, goal_y, goal_angle, output ready);
endinterface

interface hpid_result_if;
  logic               valid;
  logic               ready;
  logic [14:0]        linear_velocity;
  logic signed [15:0] angular_velocity;
  logic               reached;
  modport source (output valid, linear_velocity, angular_velocity, reached, input ready);
  modport sink (input valid, linear_velocity, angular_velocity, reached, output ready);
endinterface

// ----- src/heading_pid_point_controller_top.sv -----
`timescale 1ns / 1ps
// One word at a time: op 0 runs the shared CORDIC unit twice (yaw, then bearing) unless the
// target is already reached, op 1 runs it once (yaw); a run whose operands are both zero skips
// its normalising pass and iterations, which otherwise shifts the operands until large enough.
// A new word can be accepted in the cycle after the result is registered.
// Reset (rst, synchronous) loads the register defaults, clears every robot's PID state
// through per-robot valid bits and empties the output register; no clearing pass is needed.
module heading_pid_point_controller_top import hpid_pkg::*; #(
  parameter int ROBOT_COUNT       = 16,
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  hpid_tick_if.sink            tick,
  hpid_result_if.source        result,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [CFG_W-1:0]     wr_data
);

  dp_cmd_t    cmd;
  dp_status_t st;
  tick_t      tick_word;
  res_t       res_word;
  logic       in_ready, out_valid;

  always_comb begin
    tick_word.op          = tick.op;
    tick_word.robot_index = tick.robot_index;
    tick_word.pos_x       = tick.pos_x;
    tick_word.pos_y       = tick.pos_y;
    tick_word.quat_x      = tick.quat_x;
    tick_word.quat_y      = tick.quat_y;
    tick_word.quat_z      = tick.quat_z;
    tick_word.quat_w      = tick.quat_w;
    tick_word.goal_x      = tick.goal_x;
    tick_word.goal_y      = tick.goal_y;
    tick_word.goal_angle  = tick.goal_angle;
    tick.ready              = in_ready;
    result.valid            = out_valid;
    result.linear_velocity  = res_word.linear_velocity;
    result.angular_velocity = res_word.angular_velocity;
    result.reached          = res_word.reached;
  end

  hpid_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (tick.valid),
    .in_ready  (in_ready),
    .out_ready (result.ready),
    .out_valid (out_valid),
    .st        (st),
    .cmd       (cmd)
  );

  hpid_dp #(
    .ROBOT_COUNT       (ROBOT_COUNT),
    .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .tick_word (tick_word),
    .res_word  (res_word),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data)
  );

endmodule

// ----- src/hpid_cordic.sv -----
`timescale 1ns / 1ps
module hpid_cordic import hpid_pkg::*; #(
  parameter int ITERATIONS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [CI_W-1:0]  y_in,
  input  logic signed [CI_W-1:0]  x_in,
  output logic                    done,
  output logic signed [ANG_W-1:0] angle
);

  cordic_state_t cst, cst_next;
  logic signed [CW-1:0] x, y;
  logic signed [ZW-1:0] z;
  logic [ATAN_IDX_W-1:0] i;
  logic [CW-1:0] ax, ay;
  logic small1, small4, zero_in;
  logic [ZW-1:0] z_mag, z_rnd;

  always_comb begin
    ax      = x[CW-1] ? CW'(-x) : CW'(x);
    ay      = y[CW-1] ? CW'(-y) : CW'(y);
    small1  = (ax < NORM_LIMIT) && (ay < NORM_LIMIT);
    small4  = (ax < NORM_LIMIT4) && (ay < NORM_LIMIT4);
    zero_in = (x_in == '0) && (y_in == '0);
    z_mag   = z[ZW-1] ? ZW'(-z) : ZW'(z);
    z_rnd   = (z_mag + ZW'(8)) >> 4;
    angle   = z[ZW-1] ? -$signed(z_rnd[ANG_W-1:0]) : $signed(z_rnd[ANG_W-1:0]);
  end

  always_comb begin
    cst_next = cst;
    unique case (cst)
      C_IDLE: if (start) cst_next = zero_in ? C_DONE : C_NORM;
      C_NORM: if (!small1) cst_next = C_ITER;
      C_ITER: if (i == ATAN_IDX_W'(ITERATIONS - 1)) cst_next = C_DONE;
      C_DONE: cst_next = C_IDLE;
    endcase
  end

  always_comb begin
    done = (cst == C_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cst <= C_IDLE;
    end else begin
      cst <= cst_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cst)
      C_IDLE: begin
        i <= '0;
        if (start) begin
          if (x_in[CI_W-1]) begin
            x <= -CW'(x_in);
            y <= -CW'(y_in);
            z <= y_in[CI_W-1] ? -PI_Q16 : PI_Q16;
          end else begin
            x <= CW'(x_in);
            y <= CW'(y_in);
            z <= '0;
          end
        end
      end
      C_NORM: begin
        if (small4) begin
          x <= x <<< 4;
          y <= y <<< 4;
        end else if (small1) begin
          x <= x <<< 1;
          y <= y <<< 1;
        end
      end
      C_ITER: begin
        if (y > 0) begin
          x <= x + (y >>> i);
          y <= y - (x >>> i);
          z <= z + $signed(ATAN_Q16[i]);
        end else begin
          x <= x - (y >>> i);
          y <= y + (x >>> i);
          z <= z - $signed(ATAN_Q16[i]);
        end
        i <= i + 1'b1;
      end
      C_DONE: begin
      end
    endcase
  end

endmodule

// ----- src/hpid_ctrl.sv -----
`timescale 1ns / 1ps
module hpid_ctrl import hpid_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       out_ready,
  output logic       out_valid,
  input  dp_status_t st,
  output dp_cmd_t    cmd
);

  ctrl_state_t state, state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      CS_IDLE:     if (in_valid) state_next = CS_DX;
      CS_DX:       state_next = CS_DY;
      CS_DY:       state_next = CS_TOL;
      CS_TOL:      state_next = CS_WW;
      CS_WW:       state_next = CS_XX;
      CS_XX:       state_next = CS_YY;
      CS_YY:       state_next = CS_ZZ;
      CS_ZZ:       state_next = CS_XY;
      CS_XY:       state_next = CS_WZ;
      CS_WZ:       state_next = CS_XZ;
      CS_XZ:       state_next = CS_WY;
      CS_WY:       state_next = (!st.op && st.near) ? CS_DONE : CS_YAW_GO;
      CS_YAW_GO:   state_next = CS_YAW_WAIT;
      CS_YAW_WAIT: if (st.cordic_done) state_next = st.op ? CS_ERR : CS_BRG_GO;
      CS_BRG_GO:   state_next = CS_BRG_WAIT;
      CS_BRG_WAIT: if (st.cordic_done) state_next = CS_ERR;
      CS_ERR:      state_next = st.op ? CS_DONE : CS_DIV;
      CS_DIV:      state_next = CS_MP;
      CS_MP:       state_next = CS_MI;
      CS_MI:       state_next = CS_MD;
      CS_MD:       state_next = CS_DONE;
      CS_DONE:     if (!out_valid || out_ready) state_next = CS_IDLE;
      default:     state_next = CS_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.mul  = MUL_NONE;
    in_ready = 1'b0;
    unique case (state)
      CS_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      CS_DX:       cmd.mul = MUL_DX;
      CS_DY:       cmd.mul = MUL_DY;
      CS_TOL:      cmd.mul = MUL_TOL;
      CS_WW:       cmd.mul = MUL_WW;
      CS_XX:       cmd.mul = MUL_XX;
      CS_YY:       cmd.mul = MUL_YY;
      CS_ZZ:       cmd.mul = MUL_ZZ;
      CS_XY:       cmd.mul = MUL_XY;
      CS_WZ:       cmd.mul = MUL_WZ;
      CS_XZ:       cmd.mul = MUL_XZ;
      CS_WY:       cmd.mul = MUL_WY;
      CS_YAW_GO:   cmd.cordic_start = 1'b1;
      CS_YAW_WAIT: begin
      end
      CS_BRG_GO: begin
        cmd.cordic_start = 1'b1;
        cmd.cordic_brg   = 1'b1;
      end
      CS_BRG_WAIT: cmd.cordic_brg = 1'b1;
      CS_ERR:      cmd.err_latch = 1'b1;
      CS_DIV:      cmd.mul = MUL_RECIP;
      CS_MP:       cmd.mul = MUL_P;
      CS_MI:       cmd.mul = MUL_I;
      CS_MD:       cmd.mul = MUL_D;
      CS_DONE:     cmd.finish = !out_valid || out_ready;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= CS_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- src/hpid_dp.sv -----
`timescale 1ns / 1ps
module hpid_dp import hpid_pkg::*; #(
  parameter int ROBOT_COUNT       = 16,
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dp_cmd_t              cmd,
  output dp_status_t           st,
  input  tick_t                tick_word,
  output res_t                 res_word,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [CFG_W-1:0]     wr_data
);

  localparam int RW = (ROBOT_COUNT > 1) ? $clog2(ROBOT_COUNT) : 1;

  logic [CFG_W-1:0] pos_tol, ang_tol, ang_lim, lin_speed, gain_p, gain_i, gain_d, wide_tol;

  logic                    op_r;
  logic [RW-1:0]           ridx;
  logic signed [16:0]      dx, dy;
  logic signed [15:0]      qx, qy, qz, qw;
  logic signed [14:0]      goal_a;

  logic [RW-1:0]           rmod [16];

  logic signed [MA_W-1:0]  mul_a;
  logic signed [MB_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;

  logic [DIST_W-1:0]       dist_sq;
  logic                    near;
  logic [QACC_W-1:0]       qlen;
  logic signed [QACC_W-1:0] xq, yq, gq;

  logic                    degenerate;
  logic [CI_W-1:0]         g_mag;
  logic signed [CI_W-1:0]  c_x, c_y;
  logic                    c_done;
  logic signed [ANG_W-1:0] c_angle;
  logic signed [ANG_W-1:0] yaw, brg;

  logic signed [ERR_W-1:0] a_src, diff, wrap1, wrap2, e;
  logic [ERR_W-1:0]        e_mag;
  logic [ERR_W:0]          recip_n;

  logic [31:0]             mem [ROBOT_COUNT];
  logic [31:0]             rd_q;
  logic [ROBOT_COUNT-1:0]  vld;
  logic signed [15:0]      integ_old, prev_old;

  logic signed [15:0]      rq;
  logic signed [18:0]      de;
  logic signed [DER_W-1:0] deriv;
  logic signed [16:0]      isum;
  logic signed [INT_W-1:0] integ, integ_next;
  logic signed [SUM_W-1:0] sum;

  logic [SUM_W-1:0]        sum_mag, r12, r13;
  logic [15:0]             m12;
  logic [16:0]             m13;
  logic                    wide, rot_reached;
  res_t                    res_next;

  for (genvar g = 0; g < 16; g++) begin : g_rmod
    assign rmod[g] = RW'(g % ROBOT_COUNT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_tol   <= RST_POS_TOL;
      ang_tol   <= RST_ANG_TOL;
      ang_lim   <= RST_ANG_LIM;
      lin_speed <= RST_LIN_SPEED;
      gain_p    <= RST_GAIN_P;
      gain_i    <= RST_GAIN_I;
      gain_d    <= RST_GAIN_D;
      wide_tol  <= RST_WIDE_TOL;
    end else if (wr_en) begin
      unique case (cfg_idx_t'(wr_index))
        CFG_POS_TOL:   pos_tol   <= wr_data;
        CFG_ANG_TOL:   ang_tol   <= wr_data;
        CFG_ANG_LIM:   ang_lim   <= wr_data;
        CFG_LIN_SPEED: lin_speed <= wr_data;
        CFG_GAIN_P:    gain_p    <= wr_data;
        CFG_GAIN_I:    gain_i    <= wr_data;
        CFG_GAIN_D:    gain_d    <= wr_data;
        CFG_WIDE_TOL:  wide_tol  <= wr_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= tick_word.op;
      ridx   <= rmod[tick_word.robot_index];
      dx     <= 17'(tick_word.goal_x) - 17'(tick_word.pos_x);
      dy     <= 17'(tick_word.goal_y) - 17'(tick_word.pos_y);
      qx     <= tick_word.quat_x;
      qy     <= tick_word.quat_y;
      qz     <= tick_word.quat_z;
      qw     <= tick_word.quat_w;
      goal_a <= tick_word.goal_angle;
    end
  end

  always_comb begin
    e_mag   = e[ERR_W-1] ? ERR_W'(-e) : ERR_W'(e);
    recip_n = {1'b0, e_mag} + (ERR_W+1)'(5);
    mul_a   = '0;
    mul_b   = '0;
    unique case (cmd.mul)
      MUL_NONE: begin
      end
      MUL_DX: begin mul_a = MA_W'(dx); mul_b = MB_W'(dx); end
      MUL_DY: begin mul_a = MA_W'(dy); mul_b = MB_W'(dy); end
      MUL_TOL: begin
        mul_a = MA_W'(pos_tol);
        mul_b = MB_W'(pos_tol);
      end
      MUL_WW: begin mul_a = MA_W'(qw); mul_b = MB_W'(qw); end
      MUL_XX: begin mul_a = MA_W'(qx); mul_b = MB_W'(qx); end
      MUL_YY: begin mul_a = MA_W'(qy); mul_b = MB_W'(qy); end
      MUL_ZZ: begin mul_a = MA_W'(qz); mul_b = MB_W'(qz); end
      MUL_XY: begin mul_a = MA_W'(qx); mul_b = MB_W'(qy); end
      MUL_WZ: begin mul_a = MA_W'(qw); mul_b = MB_W'(qz); end
      MUL_XZ: begin mul_a = MA_W'(qx); mul_b = MB_W'(qz); end
      MUL_WY: begin mul_a = MA_W'(qw); mul_b = MB_W'(qy); end
      MUL_RECIP: begin
        mul_a = MA_W'(recip_n);
        mul_b = RECIP_10;
      end
      MUL_P: begin mul_a = MA_W'(e);     mul_b = MB_W'(gain_p); end
      MUL_I: begin mul_a = MA_W'(integ); mul_b = MB_W'(gain_i); end
      MUL_D: begin mul_a = MA_W'(deriv); mul_b = MB_W'(gain_d); end
    endcase
    prod = mul_a * mul_b;
  end

  always_comb begin
    isum = 17'(integ_old) + 17'(rq);
    if (isum > INTEGRAL_LIMIT) begin
      integ_next = INT_W'(INTEGRAL_LIMIT);
    end else if (isum < -INTEGRAL_LIMIT) begin
      integ_next = INT_W'(-INTEGRAL_LIMIT);
    end else begin
      integ_next = INT_W'(isum);
    end
    de = 19'(e) - 19'(prev_old);
  end

  always_ff @(posedge clk) begin
    unique case (cmd.mul)
      MUL_NONE: begin
      end
      MUL_DX:  dist_sq <= DIST_W'(prod);
      MUL_DY:  dist_sq <= dist_sq + DIST_W'(prod);
      MUL_TOL: near <= dist_sq < DIST_W'(prod);
      MUL_WW: begin
        qlen <= QACC_W'(prod);
        xq   <= QACC_W'(prod);
      end
      MUL_XX: begin
        qlen <= qlen + QACC_W'(prod);
        xq   <= xq + QACC_W'(prod);
      end
      MUL_YY: begin
        qlen <= qlen + QACC_W'(prod);
        xq   <= xq - QACC_W'(prod);
      end
      MUL_ZZ: begin
        qlen <= qlen + QACC_W'(prod);
        xq   <= xq - QACC_W'(prod);
      end
      MUL_XY:  yq <= QACC_W'(prod);
      MUL_WZ:  yq <= yq + QACC_W'(prod);
      MUL_XZ:  gq <= QACC_W'(prod);
      MUL_WY:  gq <= gq - QACC_W'(prod);
      MUL_RECIP: begin
        rq    <= e[ERR_W-1] ? -$signed(prod[RECIP_SHIFT +: 16])
                            : $signed(prod[RECIP_SHIFT +: 16]);
        deriv <= (DER_W'(de) <<< 3) + (DER_W'(de) <<< 1);
      end
      MUL_P: begin
        integ <= integ_next;
        sum   <= SUM_W'(prod);
      end
      MUL_I:   sum <= sum + SUM_W'(prod);
      MUL_D:   sum <= sum + SUM_W'(prod);
    endcase
  end

  always_comb begin
    g_mag      = gq[QACC_W-1] ? {CI_W'(-gq)} << 1 : {CI_W'(gq)} << 1;
    degenerate = (qlen == '0) || (g_mag >= CI_W'(qlen));
    if (cmd.cordic_brg) begin
      c_y = CI_W'(dy);
      c_x = CI_W'(dx);
    end else if (degenerate) begin
      c_y = '0;
      c_x = '0;
    end else begin
      c_y = CI_W'(yq) <<< 1;
      c_x = CI_W'(xq);
    end
  end

  hpid_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.cordic_start),
    .y_in  (c_y),
    .x_in  (c_x),
    .done  (c_done),
    .angle (c_angle)
  );

  always_ff @(posedge clk) begin
    if (c_done) begin
      if (cmd.cordic_brg) begin
        brg <= c_angle;
      end else begin
        yaw <= c_angle;
      end
    end
  end

  always_comb begin
    a_src = op_r ? ERR_W'(goal_a) : ERR_W'(brg);
    diff  = a_src - ERR_W'(yaw);
    wrap1 = (diff > PI_Q12) ? diff - TWO_PI_Q12 : diff;
    wrap2 = (wrap1 < -PI_Q12) ? wrap1 + TWO_PI_Q12 : wrap1;
  end

  always_ff @(posedge clk) begin
    if (cmd.err_latch) begin
      e <= wrap2;
    end
  end

  always_ff @(posedge clk) begin
    rd_q <= mem[ridx];
    if (cmd.finish && !op_r) begin
      mem[ridx] <= near ? 32'd0 : {16'(integ), 16'(e)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (cmd.finish && !op_r) begin
      vld[ridx] <= 1'b1;
    end
  end

  always_comb begin
    integ_old = vld[ridx] ? $signed(rd_q[31:16]) : 16'sd0;
    prev_old  = vld[ridx] ? $signed(rd_q[15:0]) : 16'sd0;
  end

  always_comb begin
    sum_mag     = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
    r12         = (sum_mag + SUM_W'(2048)) >> 12;
    r13         = (sum_mag + SUM_W'(4096)) >> 13;
    m12         = (r12 > SUM_W'(ang_lim)) ? 16'(ang_lim) : r12[15:0];
    if (sum[SUM_W-1]) begin
      m13 = (r13 > SUM_W'(32768)) ? 17'd32768 : r13[16:0];
    end else begin
      m13 = (r13 > SUM_W'(32767)) ? 17'd32767 : r13[16:0];
    end
    wide        = e_mag > ERR_W'(wide_tol);
    rot_reached = e_mag < ERR_W'(ang_tol);
    res_next    = '0;
    if (op_r) begin
      res_next.reached = rot_reached;
      if (!rot_reached) begin
        res_next.angular_velocity = (e > 0) ? $signed(16'(ang_lim)) : -$signed(16'(ang_lim));
      end
    end else if (near) begin
      res_next.reached = 1'b1;
    end else if (wide) begin
      res_next.angular_velocity = sum[SUM_W-1] ? -$signed(m12) : $signed(m12);
    end else begin
      res_next.linear_velocity  = lin_speed;
      res_next.angular_velocity = sum[SUM_W-1] ? 16'(-m13) : 16'(m13);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_word <= res_next;
    end
  end

  always_comb begin
    st.op          = op_r;
    st.near        = near;
    st.cordic_done = c_done;
  end

endmodule

// ----- dv/hpid_checker.sv -----
`timescale 1ns / 1ps
module hpid_checker import hpid_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  hpid_tick_if                 tick,
  hpid_result_if               result,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [CFG_W-1:0]     wr_data,
  output int                   fails,
  output int                   outstanding
);

  localparam longint ATAN_TAB [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                       256, 128, 64, 32, 16, 8, 4, 2};

  logic [CFG_W-1:0] pos_tol, ang_tol, ang_lim, lin_speed, kp, ki, kd, wide_tol;
  longint integ_acc [16];
  longint last_err [16];
  res_t   expected_cmds [$];

  function automatic longint round_div(longint v, longint d);
    if (v >= 0) return (v + d / 2) / d;
    return -((-v + d / 2) / d);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint abs64(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint bearing(longint y, longint x);
    longint z, nx, ny;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? 205887 : -205887;
      x = -x;
      y = -y;
    end
    while (abs64(x) < 536870912 && abs64(y) < 536870912) begin
      x = x * 2;
      y = y * 2;
    end
    for (int i = 0; i < 16; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z += ATAN_TAB[i];
      end else begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z -= ATAN_TAB[i];
      end
      x = nx;
      y = ny;
    end
    return round_div(z, 16);
  endfunction

  function automatic longint heading_of(tick_t t);
    longint qx, qy, qz, qw, len, g;
    qx = t.quat_x;
    qy = t.quat_y;
    qz = t.quat_z;
    qw = t.quat_w;
    len = qw * qw + qx * qx + qy * qy + qz * qz;
    g = 2 * (qx * qz - qw * qy);
    if (len == 0 || abs64(g) >= len) return 0;
    return bearing(2 * (qx * qy + qw * qz), qw * qw + qx * qx - qy * qy - qz * qz);
  endfunction

  function automatic longint wrap_pi(longint a);
    if (a > 12868) a -= 25736;
    if (a < -12868) a += 25736;
    return a;
  endfunction

  function automatic res_t steer(tick_t t);
    res_t   r;
    int     n;
    longint lin, ang, dx, dy, e, ig, dv, sum, lim, d;
    n = t.robot_index;
    lin = 0;
    ang = 0;
    lim = ang_lim;
    r.reached = 1'b0;
    if (t.op == 1'b0) begin
      dx = longint'(t.goal_x) - longint'(t.pos_x);
      dy = longint'(t.goal_y) - longint'(t.pos_y);
      if (dx * dx + dy * dy < longint'(pos_tol) * longint'(pos_tol)) begin
        r.reached = 1'b1;
        integ_acc[n] = 0;
        last_err[n] = 0;
      end else begin
        e = wrap_pi(bearing(dy, dx) - heading_of(t));
        ig = clip(integ_acc[n] + round_div(e, 10), -4096, 4096);
        dv = (e - last_err[n]) * 10;
        sum = longint'(kp) * e + longint'(ki) * ig + longint'(kd) * dv;
        integ_acc[n] = ig;
        last_err[n] = e;
        if (abs64(e) > longint'(wide_tol)) begin
          ang = clip(round_div(sum, 4096), -lim, lim);
        end else begin
          lin = lin_speed;
          ang = clip(round_div(sum, 8192), -32768, 32767);
        end
      end
    end else begin
      d = wrap_pi(longint'(t.goal_angle) - heading_of(t));
      if (abs64(d) < longint'(ang_tol)) r.reached = 1'b1;
      else ang = (d > 0) ? lim : -lim;
    end
    r.linear_velocity = lin[14:0];
    r.angular_velocity = ang[15:0];
    return r;
  endfunction

  assign outstanding = expected_cmds.size();

  always @(posedge clk) begin
    tick_t t;
    res_t  want;
    if (rst) begin
      pos_tol <= RST_POS_TOL;
      ang_tol <= RST_ANG_TOL;
      ang_lim <= RST_ANG_LIM;
      lin_speed <= RST_LIN_SPEED;
      kp <= RST_GAIN_P;
      ki <= RST_GAIN_I;
      kd <= RST_GAIN_D;
      wide_tol <= RST_WIDE_TOL;
      for (int i = 0; i < 16; i++) begin
        integ_acc[i] = 0;
        last_err[i] = 0;
      end
      expected_cmds.delete();
      fails = 0;
    end else begin
      if (wr_en) begin
        case (cfg_idx_t'(wr_index))
          CFG_POS_TOL:   pos_tol <= wr_data;
          CFG_ANG_TOL:   ang_tol <= wr_data;
          CFG_ANG_LIM:   ang_lim <= wr_data;
          CFG_LIN_SPEED: lin_speed <= wr_data;
          CFG_GAIN_P:    kp <= wr_data;
          CFG_GAIN_I:    ki <= wr_data;
          CFG_GAIN_D:    kd <= wr_data;
          CFG_WIDE_TOL:  wide_tol <= wr_data;
          default: ;
        endcase
      end
      if (tick.valid && tick.ready) begin
        t.op = tick.op;
        t.robot_index = tick.robot_index;
        t.pos_x = tick.pos_x;
        t.pos_y = tick.pos_y;
        t.quat_x = tick.quat_x;
        t.quat_y = tick.quat_y;
        t.quat_z = tick.quat_z;
        t.quat_w = tick.quat_w;
        t.goal_x = tick.goal_x;
        t.goal_y = tick.goal_y;
        t.goal_angle = tick.goal_angle;
        expected_cmds = {expected_cmds, steer(t)};
      end
      if (result.valid && result.ready) begin
        if (expected_cmds.size() == 0) begin
          fails++;
          $display("%0t: unexpected word lin=%0d ang=%0d reached=%0b", $time,
                   result.linear_velocity, result.angular_velocity, result.reached);
        end else begin
          want = expected_cmds.pop_front();
          if (result.linear_velocity !== want.linear_velocity) begin
            fails++;
            $display("%0t: linear_velocity expected %0d actual %0d", $time,
                     want.linear_velocity, result.linear_velocity);
          end
          if (result.angular_velocity !== want.angular_velocity) begin
            fails++;
            $display("%0t: angular_velocity expected %0d actual %0d", $time,
                     want.angular_velocity, result.angular_velocity);
          end
          if (result.reached !== want.reached) begin
            fails++;
            $display("%0t: reached expected %0b actual %0b", $time,
                     want.reached, result.reached);
          end
        end
      end
    end
  end

endmodule

// ----- dv/tb_heading_pid_point_controller_top.sv -----
`timescale 1ns / 1ps
module tb_heading_pid_point_controller_top;
  import hpid_pkg::*;

  localparam int STALL_LIMIT = 20000;

  logic                 clk;
  logic                 rst;
  logic                 wr_en;
  logic [CFG_IDX_W-1:0] wr_index;
  logic [CFG_W-1:0]     wr_data;
  int                   fails;
  int                   outstanding;
  int                   quiet_cycles;
  bit                   steady;

  hpid_tick_if   tick();
  hpid_result_if result();

  heading_pid_point_controller_top dut (
    .clk(clk), .rst(rst), .tick(tick), .result(result),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  hpid_checker chk (
    .clk(clk), .rst(rst), .tick(tick), .result(result),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .fails(fails), .outstanding(outstanding)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
    end else begin
      result.ready <= steady || ($urandom_range(0, 99) >= 34);
    end
  end

  always @(posedge clk) begin
    if ((tick.valid && tick.ready) || (result.valid && result.ready) || rst) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic tick_t mk(bit op, int r, int px, int py, int qx, int qy, int qz, int qw,
                               int gx, int gy, int ga);
    tick_t t;
    t.op = op;
    t.robot_index = r[3:0];
    t.pos_x = px[15:0];
    t.pos_y = py[15:0];
    t.quat_x = qx[15:0];
    t.quat_y = qy[15:0];
    t.quat_z = qz[15:0];
    t.quat_w = qw[15:0];
    t.goal_x = gx[15:0];
    t.goal_y = gy[15:0];
    t.goal_angle = ga[14:0];
    return t;
  endfunction

  function automatic int quat_part();
    return int'($urandom_range(0, 32768)) - 16384;
  endfunction

  function automatic tick_t random_tick();
    tick_t t;
    real   a;
    int    px, py, qx, qy, qz, qw, gx, gy, ga, pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      px = int'($urandom_range(0, 65535)) - 32768;
      py = int'($urandom_range(0, 65535)) - 32768;
    end else begin
      px = int'($urandom_range(0, 4095)) - 2048;
      py = int'($urandom_range(0, 4095)) - 2048;
    end
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      gx = px;
      gy = py;
    end else if (pick < 25) begin
      gx = px + int'($urandom_range(0, 80)) - 40;
      gy = py + int'($urandom_range(0, 80)) - 40;
    end else if (pick < 35) begin
      gx = int'($urandom_range(0, 65535)) - 32768;
      gy = int'($urandom_range(0, 65535)) - 32768;
    end else begin
      gx = px + int'($urandom_range(0, 2047)) - 1024;
      gy = py + int'($urandom_range(0, 2047)) - 1024;
    end
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      a = ($urandom_range(0, 62831) / 10000.0) - 3.14159;
      qx = 0;
      qy = 0;
      qz = $rtoi(16384.0 * $sin(a / 2.0));
      qw = $rtoi(16384.0 * $cos(a / 2.0));
    end else if (pick < 90) begin
      qx = quat_part();
      qy = quat_part();
      qz = quat_part();
      qw = quat_part();
    end else begin
      qx = 0;
      qy = 0;
      qz = 0;
      qw = ($urandom_range(0, 1) == 1) ? 16384 : 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 10) ga = int'($urandom_range(0, 32767)) - 16384;
    else if (pick < 15) ga = 0;
    else ga = int'($urandom_range(0, 25736)) - 12868;
    t = mk($urandom_range(0, 99) < 30, $urandom_range(0, 15), px, py, qx, qy, qz, qw,
           gx, gy, ga);
    return t;
  endfunction

  task automatic send_tick(tick_t t);
    while (!steady && $urandom_range(0, 99) < 34) begin
      tick.valid <= 1'b0;
      @(posedge clk);
    end
    tick.valid <= 1'b1;
    tick.op <= t.op;
    tick.robot_index <= t.robot_index;
    tick.pos_x <= t.pos_x;
    tick.pos_y <= t.pos_y;
    tick.quat_x <= t.quat_x;
    tick.quat_y <= t.quat_y;
    tick.quat_z <= t.quat_z;
    tick.quat_w <= t.quat_w;
    tick.goal_x <= t.goal_x;
    tick.goal_y <= t.goal_y;
    tick.goal_angle <= t.goal_angle;
    @(posedge clk);
    while (!tick.ready) @(posedge clk);
  endtask

  // drain and settle before touching the registers
  task automatic drain();
    tick.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] value);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= value;
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic set_all(int mode);
    logic [CFG_W-1:0] v;
    for (int i = 0; i < 8; i++) begin
      case (mode)
        0: v = '0;
        1: v = '1;
        default: v = CFG_W'($urandom_range(0, 32767));
      endcase
      if (mode == 2 && i != int'(CFG_POS_TOL)) v = CFG_W'($urandom_range(0, 8191));
      write_reg(cfg_idx_t'(i), v);
    end
  endtask

  initial begin
    tick_t directed [$];
    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = '0;
    wr_data = '0;
    tick.valid = 1'b0;
    tick.op = 1'b0;
    tick.robot_index = '0;
    tick.pos_x = '0;
    tick.pos_y = '0;
    tick.quat_x = '0;
    tick.quat_y = '0;
    tick.quat_z = '0;
    tick.quat_w = '0;
    tick.goal_x = '0;
    tick.goal_y = '0;
    tick.goal_angle = '0;
    steady = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed = {directed, mk(0, 0, 100, 100, 0, 0, 0, 16384, 100, 100, 0)};
    directed = {directed, mk(0, 15, 0, 0, 0, 0, 0, 16384, 2560, 0, 0)};
    directed = {directed, mk(0, 15, 0, 0, 0, 0, 0, 16384, 2560, 100, 0)};
    directed = {directed, mk(0, 15, 0, 0, 0, 0, 16384, 0, 2560, 0, 0)};
    directed = {directed, mk(0, 3, 0, 0, 0, 0, 0, 0, -2560, -10, 0)};
    directed = {directed, mk(0, 4, 0, 0, 0, 11585, 0, 11585, 0, 2560, 0)};
    directed = {directed, mk(0, 5, -32768, -32768, 0, 0, 0, 16384, 32767, 32767, 0)};
    directed = {directed, mk(0, 5, 32767, 32767, -16384, -16384, -16384, -16384,
                             -32768, -32768, 0)};
    directed = {directed, mk(0, 6, 0, 0, 0, 0, 11585, 11585, -2560, 0, 0)};
    directed = {directed, mk(0, 6, 0, 0, 16384, 16384, 16384, 16384, 0, -2560, 0)};
    directed = {directed, mk(0, 7, 0, 0, 0, 0, 0, 16384, 20, 0, 0)};
    directed = {directed, mk(1, 8, 0, 0, 0, 0, 0, 16384, 0, 0, 100)};
    directed = {directed, mk(1, 8, 0, 0, 0, 0, 0, 16384, 0, 0, 12868)};
    directed = {directed, mk(1, 8, 0, 0, 0, 0, 0, 16384, 0, 0, -12868)};
    directed = {directed, mk(1, 9, 0, 0, 0, 0, 16384, 0, 0, 0, 16383)};
    directed = {directed, mk(1, 9, 0, 0, 0, 0, 0, 16384, 0, 0, -16384)};
    directed = {directed, mk(1, 10, 0, 0, 0, 0, 0, 0, 0, 0, 3000)};
    directed = {directed, mk(1, 10, 0, 0, 11585, 0, 11585, 0, 0, 0, -3000)};
    directed = {directed, mk(0, 0, 0, 0, 0, 0, 0, 16384, 0, 2560, 0)};
    directed = {directed, mk(0, 0, 0, 0, 0, 0, 0, 16384, 0, 2560, 0)};
    foreach (directed[i]) send_tick(directed[i]);

    for (int ph = 0; ph < 5; ph++) begin
      drain();
      case (ph)
        0: set_all(2);
        1: set_all(0);
        2: set_all(1);
        3: set_all(2);
        default: begin
          write_reg(CFG_POS_TOL, RST_POS_TOL);
          write_reg(CFG_ANG_TOL, RST_ANG_TOL);
          write_reg(CFG_ANG_LIM, RST_ANG_LIM);
          write_reg(CFG_LIN_SPEED, RST_LIN_SPEED);
          write_reg(CFG_GAIN_P, RST_GAIN_P);
          write_reg(CFG_GAIN_I, RST_GAIN_I);
          write_reg(CFG_GAIN_D, RST_GAIN_D);
          write_reg(CFG_WIDE_TOL, RST_WIDE_TOL);
        end
      endcase
      if (ph == 1) send_tick(mk(0, 2, 0, 0, 0, 0, 0, 16384, 0, 0, 0));
      if (ph == 1) send_tick(mk(1, 2, 0, 0, 0, 0, 0, 16384, 0, 0, 0));
      for (int n = 0; n < 120; n++) begin
        steady = (ph == 3 && n >= 20 && n < 90);
        send_tick(random_tick());
      end
      steady = 1'b0;
    end

    tick.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
